[design/asdu_cp_pkg.sv]
// Package for the ASDU command parser: transaction payload types, byte phase
// codes, supported type identifications and type classification helpers.
// No dependencies.
package asdu_cp_pkg;

   // Input transaction: one ASDU byte and its start-of-unit flag
   typedef struct packed {
      logic [7:0] byte_in;
      logic       frame_start;
   } req_payload_type;

   // Result transaction: one parsed information object or an error report
   typedef struct packed {
      logic [7:0]  type_ident;
      logic [5:0]  cause_code;
      logic        confirm_bit;
      logic        test_bit;
      logic [7:0]  originator;
      logic [15:0] common_address;
      logic [23:0] object_address;
      logic [7:0]  element_byte;
      logic [55:0] time_tag;
      logic        status;
      logic        last_object;
   } rsp_payload_type;

   // Parser to output register: result strobe plus payload
   typedef struct packed {
      logic            emit;
      rsp_payload_type data;
   } result_type;

   // Byte phases; the seventh time byte shares its code with idle
   localparam logic [3:0] PH_TIME7 = 4'd0;
   localparam logic [3:0] PH_COUNT = 4'd1;
   localparam logic [3:0] PH_CAUSE = 4'd2;
   localparam logic [3:0] PH_ORIG  = 4'd3;
   localparam logic [3:0] PH_CA_LO = 4'd4;
   localparam logic [3:0] PH_CA_HI = 4'd5;
   localparam logic [3:0] PH_IOA0  = 4'd6;
   localparam logic [3:0] PH_IOA1  = 4'd7;
   localparam logic [3:0] PH_IOA2  = 4'd8;
   localparam logic [3:0] PH_ELEM  = 4'd9;
   localparam logic [3:0] PH_TIME1 = 4'd10;

   // Status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BADTYPE = 1'b1;

   // Supported command type identifications
   localparam logic [7:0] TYPE_SC_NA = 8'd45;
   localparam logic [7:0] TYPE_DC_NA = 8'd46;
   localparam logic [7:0] TYPE_SC_TA = 8'd58;
   localparam logic [7:0] TYPE_DC_TA = 8'd59;
   localparam logic [7:0] TYPE_IC_NA = 8'd100;
   localparam logic [7:0] TYPE_CI_NA = 8'd101;
   localparam logic [7:0] TYPE_CS_NA = 8'd103;

   function automatic logic type_has_element(input logic [7:0] t);
      return (t == TYPE_SC_NA) || (t == TYPE_DC_NA) || (t == TYPE_SC_TA) ||
             (t == TYPE_DC_TA) || (t == TYPE_IC_NA) || (t == TYPE_CI_NA);
   endfunction

   function automatic logic type_has_time(input logic [7:0] t);
      return (t == TYPE_SC_TA) || (t == TYPE_DC_TA) || (t == TYPE_CS_NA);
   endfunction

endpackage

[design/asdu_cp_parse.sv]
// Byte-phase parser: header and object field registers, phase sequencing
// and result formation. Depends on asdu_cp_pkg.
module asdu_cp_parse
   import asdu_cp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type item,
   output result_type      res
);

   logic [3:0]  phase_ff,   phase_in;
   logic        idle_ff,    idle_in;
   logic [6:0]  done_ff,    done_in;
   logic [6:0]  count_ff,   count_in;
   logic        seq_ff,     seq_in;
   logic [7:0]  type_ff,    type_in;
   logic [7:0]  cause_ff,   cause_in;
   logic [7:0]  orig_ff,    orig_in;
   logic [15:0] common_ff,  common_in;
   logic [23:0] first_ff,   first_in;
   logic [23:0] addr_ff,    addr_in;
   logic [7:0]  elem_ff,    elem_in;
   logic [55:0] time_ff,    time_in;

   logic        finish;
   logic        badtype;
   logic        last;
   logic [6:0]  done_inc;
   logic [3:0]  body_phase;
   logic [7:0]  b;

   assign b          = item.byte_in;
   assign done_inc   = done_ff + 7'd1;
   assign body_phase = type_has_element(type_ff) ? PH_ELEM : PH_TIME1;

   // Next state for one accepted byte
   always_comb begin
      phase_in  = phase_ff;
      idle_in   = idle_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      type_in   = type_ff;
      cause_in  = cause_ff;
      orig_in   = orig_ff;
      common_in = common_ff;
      first_in  = first_ff;
      addr_in   = addr_ff;
      elem_in   = elem_ff;
      time_in   = time_ff;
      finish    = 1'b0;
      badtype   = 1'b0;
      last      = 1'b0;
      if (step) begin
         if (item.frame_start) begin
            type_in  = b;
            done_in  = '0;
            idle_in  = 1'b0;
            phase_in = PH_COUNT;
         end else if (!idle_ff) begin
            unique case (phase_ff)
               PH_COUNT: begin
                  count_in = b[6:0];
                  seq_in   = b[7];
                  phase_in = PH_CAUSE;
               end
               PH_CAUSE: begin
                  cause_in = b;
                  phase_in = PH_ORIG;
               end
               PH_ORIG: begin
                  orig_in  = b;
                  phase_in = PH_CA_LO;
               end
               PH_CA_LO: begin
                  common_in = {8'd0, b};
                  phase_in  = PH_CA_HI;
               end
               PH_CA_HI: begin
                  common_in = {b, common_ff[7:0]};
                  if (count_ff == 7'd0) begin
                     idle_in  = 1'b1;
                     phase_in = PH_TIME7;
                  end else if (!(type_has_element(type_ff) || type_has_time(type_ff))) begin
                     badtype  = 1'b1;
                     idle_in  = 1'b1;
                     phase_in = PH_TIME7;
                  end else begin
                     phase_in = PH_IOA0;
                  end
               end
               PH_IOA0: begin
                  addr_in  = {16'd0, b};
                  phase_in = PH_IOA1;
               end
               PH_IOA1: begin
                  addr_in  = {8'd0, b, addr_ff[7:0]};
                  phase_in = PH_IOA2;
               end
               PH_IOA2: begin
                  addr_in = {b, addr_ff[15:0]};
                  if (done_ff == 7'd0) begin
                     first_in = {b, addr_ff[15:0]};
                  end
                  phase_in = body_phase;
               end
               PH_ELEM: begin
                  elem_in = b;
                  if (type_has_time(type_ff)) begin
                     phase_in = PH_TIME1;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  // time bytes: first received ends up least significant
                  time_in = {b, time_ff[55:8]};
                  if (phase_ff == PH_TIME7) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end
            endcase

            // object complete: count it and pick the next phase
            if (finish) begin
               done_in = done_inc;
               last    = (done_inc == count_ff);
               if (last) begin
                  idle_in  = 1'b1;
                  phase_in = PH_TIME7;
               end else if (seq_ff) begin
                  addr_in  = first_ff;
                  phase_in = body_phase;
               end else begin
                  phase_in = PH_IOA0;
               end
            end
         end
      end
   end

   // Result formation
   always_comb begin
      res.emit                = finish || badtype;
      res.data.type_ident     = type_ff;
      res.data.cause_code     = cause_ff[5:0];
      res.data.confirm_bit    = cause_ff[6];
      res.data.test_bit       = cause_ff[7];
      res.data.originator     = orig_ff;
      res.data.common_address = common_in;
      if (badtype) begin
         res.data.object_address = '0;
         res.data.element_byte   = '0;
         res.data.time_tag       = '0;
         res.data.status         = STATUS_BADTYPE;
         res.data.last_object    = 1'b1;
      end else begin
         res.data.object_address = addr_in;
         res.data.element_byte   = type_has_element(type_ff) ? elem_in : 8'd0;
         res.data.time_tag       = type_has_time(type_ff) ? time_in : 56'd0;
         res.data.status         = STATUS_OK;
         res.data.last_object    = last;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TIME7;
         idle_ff  <= 1'b1;
         done_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         idle_ff  <= idle_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Field registers
   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      type_ff   <= type_in;
      cause_ff  <= cause_in;
      orig_ff   <= orig_in;
      common_ff <= common_in;
      first_ff  <= first_in;
      addr_ff   <= addr_in;
      elem_ff   <= elem_in;
      time_ff   <= time_in;
   end

   // Idle always parks the phase at its rest code
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      idle_ff |-> (phase_ff == PH_TIME7))
      else $error("idle with a live byte phase");

   // Results only come from an accepted byte of a live unit
   a_emit_live: assert property (@(posedge clock) disable iff (reset)
      res.emit |-> (step && !idle_ff && !item.frame_start))
      else $error("result without a live unit");

   // Object counter never passes the header count
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff <= count_ff)
      else $error("object counter overran header count");

   // An error report always closes the unit
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (res.emit && res.data.status == STATUS_BADTYPE) |-> res.data.last_object)
      else $error("error result not marked last");

endmodule

[design/asdu_cp_out_reg.sv]
// Result register: holds one finished transaction until the consumer takes it.
// Depends on asdu_cp_pkg.
module asdu_cp_out_reg
   import asdu_cp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_type      res,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // load wins; the parser only fires when the slot is free or draining
   always_comb begin
      valid_in = valid_ff;
      if (res.emit) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.emit) begin
         data_ff <= res.data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

[design/asdu_command_parser.sv]
// Byte-serial IEC 104 command ASDU parser, top level.
// Throughput: one byte per cycle, sustained, while results are taken.
// A result becomes valid once the byte that completes it has passed the input
// register and then the result register.
// Reset (synchronous, active high): parser idle, waiting for a start byte;
// input and result registers empty.
module asdu_command_parser
   import asdu_cp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            advance;
   logic            req_take;
   result_type      res;

   // Byte moves into the parser when the result slot can take a transaction
   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
   end

   asdu_cp_parse u_parse (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_data_ff),
      .res   (res)
   );

   asdu_cp_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .res         (res),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // A held result never gets overwritten by a new one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !res.emit)
      else $error("result overwritten while stalled");

endmodule
